// ----- src/rmq_pkg.sv -----
// Shared constants and types for the rotation matrix to quaternion unit.
package rmq_pkg;

   // Default fraction bits of the Q2.F fixed-point format
   localparam int FRAC_BITS_DEF = 16;

   // Small-w threshold register
   localparam int LIMIT_W = 17;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd66;

   // Result path codes
   typedef enum logic [1:0] {
      PATH_TRACE = 2'd0,
      PATH_X     = 2'd1,
      PATH_Y     = 2'd2,
      PATH_Z     = 2'd3
   } path_type;

   // Per-lane divider status
   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
   } div_flags_type;

endpackage

// ----- src/rmq_sqrt_pipe.sv -----
// Pipelined restoring integer square root, several lanes, one result bit per stage.
module rmq_sqrt_pipe #(
   parameter int RW    = 36,
   parameter int LANES = 3,
   parameter int SW    = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [RW-1:0]     rad_i  [LANES],
   input  logic [SW-1:0]     side_i,
   output logic [RW/2-1:0]   root_o [LANES],
   output logic [SW-1:0]     side_o
);

   localparam int NR = RW / 2;

   logic [NR+1:0] rem_ff  [NR-1][LANES];
   logic [RW-1:0] rad_ff  [NR-1][LANES];
   logic [NR-1:0] root_ff [NR][LANES];
   logic [SW-1:0] side_ff [NR];

   for (genvar k = 0; k < NR; k++) begin : g_stage
      // sideband travels with the word
      if (k == 0) begin : g_side0
         always_ff @(posedge clock) begin
            if (en) side_ff[k] <= side_i;
         end
      end else begin : g_siden
         always_ff @(posedge clock) begin
            if (en) side_ff[k] <= side_ff[k-1];
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NR+1:0] rem_prev, remx, trial, rem_in;
         logic [NR-1:0] root_prev, root_in;
         logic [RW-1:0] rad_prev;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_i[l];
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1][l];
            assign root_prev = root_ff[k-1][l];
            assign rad_prev  = rad_ff[k-1][l];
         end

         // bring down two radicand bits, try root*4+1
         assign remx  = {rem_prev[NR-1:0], rad_prev[RW-1:RW-2]};
         assign trial = {root_prev, 2'b01};

         always_comb begin
            if (remx >= trial) begin
               rem_in  = remx - trial;
               root_in = {root_prev[NR-2:0], 1'b1};
            end else begin
               rem_in  = remx;
               root_in = {root_prev[NR-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) root_ff[k][l] <= root_in;
         end

         if (k < NR - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k][l] <= rem_in;
                  rad_ff[k][l] <= {rad_prev[RW-3:0], 2'b00};
               end
            end
         end
      end
   end

   // roots from the last stage
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign root_o[l] = root_ff[NR-1][l];
   end

   assign side_o = side_ff[NR-1];

endmodule

// ----- src/rmq_div_pipe.sv -----
// Pipelined fixed-point divider: (|num| << FRAC_BITS) / den, one quotient bit per stage.
module rmq_div_pipe #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
   parameter int LANES     = 3,
   parameter int SW        = 1
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [FRAC_BITS+2:0]  num_i   [LANES],
   input  logic        [FRAC_BITS+2:0]  den_i,
   input  logic        [SW-1:0]         side_i,
   output logic        [FRAC_BITS+1:0]  q_o     [LANES],
   output rmq_pkg::div_flags_type       flags_o [LANES],
   output logic        [SW-1:0]         side_o
);

   localparam int MW = FRAC_BITS + 3;
   localparam int DW = FRAC_BITS + 3;
   localparam int QB = FRAC_BITS + 2;
   localparam int PW = DW + QB;

   // stage 0: magnitude and sign
   logic [MW-1:0] mag_ff  [LANES];
   logic          neg0_ff [LANES];
   logic [DW-1:0] den0_ff;
   logic [SW-1:0] side0_ff;

   // stage 1: overflow precheck
   logic [PW-1:0]          p1_ff     [LANES];
   rmq_pkg::div_flags_type flags1_ff [LANES];
   logic [DW-1:0]          den1_ff;
   logic [SW-1:0]          side1_ff;

   // quotient stages
   logic [PW-1:0]          p_ff     [QB][LANES];
   logic [QB-1:0]          q_ff     [QB][LANES];
   rmq_pkg::div_flags_type flags_ff [QB][LANES];
   logic [DW-1:0]          den_ff   [QB-1];
   logic [SW-1:0]          side_ff  [QB];

   always_ff @(posedge clock) begin
      if (en) begin
         den0_ff  <= den_i;
         side0_ff <= side_i;
         den1_ff  <= den0_ff;
         side1_ff <= side0_ff;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_front
      logic [PW-1:0] nsh, dsh;

      assign nsh = PW'(mag_ff[l]) << FRAC_BITS;
      assign dsh = PW'(den0_ff) << QB;

      always_ff @(posedge clock) begin
         if (en) begin
            neg0_ff[l] <= num_i[l][MW-1];
            mag_ff[l]  <= num_i[l][MW-1] ? (~num_i[l] + 1'b1) : num_i[l];
            p1_ff[l]             <= nsh;
            flags1_ff[l].neg  <= neg0_ff[l];
            flags1_ff[l].zero <= (mag_ff[l] == '0);
            flags1_ff[l].ovf  <= (nsh >= dsh);
         end
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int BIT = QB - 1 - k;
      logic [DW-1:0] den_prev;

      if (k == 0) begin : g_first
         assign den_prev = den1_ff;
         always_ff @(posedge clock) begin
            if (en) side_ff[k] <= side1_ff;
         end
      end else begin : g_next
         assign den_prev = den_ff[k-1];
         always_ff @(posedge clock) begin
            if (en) side_ff[k] <= side_ff[k-1];
         end
      end

      if (k < QB - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) den_ff[k] <= den_prev;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [PW-1:0]          p_prev, dsh, p_in;
         logic [QB-1:0]          q_prev;
         rmq_pkg::div_flags_type f_prev;
         logic                   take;

         if (k == 0) begin : g_first
            assign p_prev = p1_ff[l];
            assign q_prev = '0;
            assign f_prev = flags1_ff[l];
         end else begin : g_next
            assign p_prev = p_ff[k-1][l];
            assign q_prev = q_ff[k-1][l];
            assign f_prev = flags_ff[k-1][l];
         end

         // compare against den at this bit weight
         assign dsh  = PW'(den_prev) << BIT;
         assign take = (p_prev >= dsh);
         assign p_in = take ? (p_prev - dsh) : p_prev;

         always_ff @(posedge clock) begin
            if (en) begin
               p_ff[k][l]     <= p_in;
               q_ff[k][l]     <= {q_prev[QB-2:0], take};
               flags_ff[k][l] <= f_prev;
            end
         end

         if (k == QB - 1) begin : g_out
            assign q_o[l]     = q_ff[k][l];
            assign flags_o[l] = flags_ff[k][l];
         end
      end
   end

   assign side_o = side_ff[QB-1];

endmodule

// ----- src/rotation_matrix_to_quaternion_unit.sv -----
// Top level: rotation matrix to quaternion converter, fully pipelined.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | req_tdata: r00..r22, 9 x (FRAC_BITS+2)
//  rsp     | out | rsp_tvalid / rsp_tready | rsp_tdata: w,x,y,z; rsp_tuser: path, saturated
//  csr     | in  | csr_valid / csr_ready   | csr_data: small_w_limit
//
//  One word per cycle unless rsp stalls; 2*FRAC_BITS+8 pipeline registers:
//  the input register, FRAC_BITS+2 root stages, FRAC_BITS+4 divider stages
//  and the output register, set by the bit-per-stage root and divider.
//  Reset clears all valid bits and loads small_w_limit with 66.
//  A stall at rsp freezes the whole pipeline; req_tready drops with it.
module rotation_matrix_to_quaternion_unit #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // r00 r01 r02 r10 r11 r12 r20 r21 r22, lowest bits first, zero filled
   input  logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]     req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // quat_w quat_x quat_y quat_z, lowest bits first, zero filled
   output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0]     rsp_tdata,
   // path_taken [1:0], saturated [2]
   output logic [2:0]                               rsp_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic [rmq_pkg::LIMIT_W-1:0]              csr_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready
);

   localparam int W     = FRAC_BITS + 2;
   localparam int NW    = FRAC_BITS + 3;
   localparam int DW    = FRAC_BITS + 3;
   localparam int QB    = FRAC_BITS + 2;
   localparam int RW    = 2 * FRAC_BITS + 4;
   localparam int NR    = RW / 2;
   localparam int OW    = ((4*W+7)/8)*8;
   localparam int LW    = rmq_pkg::LIMIT_W;
   localparam int CMPW  = (NR > LW) ? NR : LW;
   localparam int SQ_SW = 6*NW + 2;
   localparam int DV_SW = 2*W + 2;
   localparam int L     = NR + QB + 4;

   localparam logic signed [FRAC_BITS+3:0] ONE_T = {3'b000, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

   logic en;
   logic [L-1:0] vld_ff;
   logic [LW-1:0] limit_ff;

   // pipeline advances unless the output word is stuck
   assign en         = !vld_ff[L-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[L-1];
   assign csr_ready  = 1'b1;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rmq_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[L-2:0], req_tvalid};
      end
   end

   // input register
   logic signed [W-1:0] r_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) r_ff[i] <= req_tdata[i*W +: W];
      end
   end

   // trace, dominant axis and radicands
   logic signed [FRAC_BITS+3:0] t;
   logic        [FRAC_BITS+2:0] a;
   logic signed [W-1:0]         d;
   logic signed [FRAC_BITS+2:0] s;
   logic        [W-1:0]         us;
   rmq_pkg::path_type           dpath;
   logic        [RW-1:0]        rad [3];
   logic signed [NW-1:0]        tnum [3];
   logic signed [NW-1:0]        dnum [3];

   function automatic logic signed [NW-1:0] ext(input logic signed [W-1:0] v);
      ext = {v[W-1], v};
   endfunction

   always_comb begin
      t = ONE_T + (FRAC_BITS+4)'(r_ff[0]) + (FRAC_BITS+4)'(r_ff[4]) + (FRAC_BITS+4)'(r_ff[8]);
      a = t[FRAC_BITS+3] ? (FRAC_BITS+3)'(-t) : t[FRAC_BITS+2:0];

      if (r_ff[0] >= r_ff[4] && r_ff[0] >= r_ff[8]) begin
         dpath = rmq_pkg::PATH_X;
         d     = r_ff[0];
      end else if (r_ff[4] >= r_ff[0] && r_ff[4] >= r_ff[8]) begin
         dpath = rmq_pkg::PATH_Y;
         d     = r_ff[4];
      end else begin
         dpath = rmq_pkg::PATH_Z;
         d     = r_ff[8];
      end
      s  = ONE_T[FRAC_BITS+2:0] + (FRAC_BITS+3)'(d);
      us = s[FRAC_BITS+2] ? '0 : s[W-1:0];

      rad[0] = RW'(a) << FRAC_BITS;
      rad[1] = RW'(us) << (FRAC_BITS - 1);
      rad[2] = RW'(us) << (FRAC_BITS + 1);

      tnum[0] = ext(r_ff[7]) - ext(r_ff[5]);
      tnum[1] = ext(r_ff[2]) - ext(r_ff[6]);
      tnum[2] = ext(r_ff[3]) - ext(r_ff[1]);

      case (dpath)
         rmq_pkg::PATH_X: begin
            dnum[0] = '0;
            dnum[1] = ext(r_ff[1]);
            dnum[2] = ext(r_ff[2]);
         end
         rmq_pkg::PATH_Y: begin
            dnum[0] = ext(r_ff[3]);
            dnum[1] = '0;
            dnum[2] = ext(r_ff[5]);
         end
         default: begin
            dnum[0] = ext(r_ff[6]);
            dnum[1] = ext(r_ff[7]);
            dnum[2] = '0;
         end
      endcase
   end

   // square roots
   logic [NR-1:0]    root [3];
   logic [SQ_SW-1:0] sq_side_in, sq_side_out;

   assign sq_side_in = {tnum[2], tnum[1], tnum[0], dnum[2], dnum[1], dnum[0], dpath};

   rmq_sqrt_pipe #(.RW(RW), .LANES(3), .SW(SQ_SW)) u_sqrt (
      .clock  (clock),
      .en     (en),
      .rad_i  (rad),
      .side_i (sq_side_in),
      .root_o (root),
      .side_o (sq_side_out)
   );

   // path decision and divider operands
   logic [NR-1:0]        w;
   logic                 trace;
   logic [1:0]           spath, opath;
   logic signed [NW-1:0] qnum [3];
   logic [DW-1:0]        den;
   logic [DV_SW-1:0]     dv_side_in, dv_side_out;

   always_comb begin
      w     = root[0] >> 1;
      trace = CMPW'(w) > CMPW'(limit_ff);
      spath = sq_side_out[1:0];
      den   = trace ? (DW'(w) << 2) : DW'(root[2]);
      opath = trace ? rmq_pkg::PATH_TRACE : spath;
      for (int i = 0; i < 3; i++) begin
         qnum[i] = trace ? sq_side_out[2 + (3+i)*NW +: NW] : sq_side_out[2 + i*NW +: NW];
      end
   end

   assign dv_side_in = {w[W-1:0], root[1][W-1:0], opath};

   logic [QB-1:0]          q     [3];
   rmq_pkg::div_flags_type flags [3];

   rmq_div_pipe #(.FRAC_BITS(FRAC_BITS), .LANES(3), .SW(DV_SW)) u_div (
      .clock   (clock),
      .en      (en),
      .num_i   (qnum),
      .den_i   (den),
      .side_i  (dv_side_in),
      .q_o     (q),
      .flags_o (flags),
      .side_o  (dv_side_out)
   );

   // saturation and root substitution
   logic [W-1:0] comp [3];
   logic [2:0]   csat;
   logic [1:0]   fpath;

   always_comb begin
      fpath = dv_side_out[1:0];
      for (int i = 0; i < 3; i++) begin
         csat[i] = 1'b0;
         if (flags[i].zero) begin
            comp[i] = '0;
         end else if (flags[i].ovf) begin
            comp[i] = flags[i].neg ? NEG_MAG : POS_MAX;
            csat[i] = 1'b1;
         end else if (flags[i].neg) begin
            if (q[i] > NEG_MAG) begin
               comp[i] = NEG_MAG;
               csat[i] = 1'b1;
            end else begin
               comp[i] = ~q[i] + 1'b1;
            end
         end else begin
            if (q[i] > POS_MAX) begin
               comp[i] = POS_MAX;
               csat[i] = 1'b1;
            end else begin
               comp[i] = q[i];
            end
         end
         if (fpath != rmq_pkg::PATH_TRACE && fpath == 2'(i + 1)) begin
            comp[i] = dv_side_out[2 +: W];
         end
      end
   end

   // output register
   logic [OW-1:0] out_data_ff;
   logic [2:0]    out_user_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= OW'({comp[2], comp[1], comp[0], dv_side_out[2+W +: W]});
         out_user_ff <= {|csat, fpath};
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

endmodule

// ----- src/rmq_checker.sv -----
// Port-level checker for the rotation matrix to quaternion unit, with its bind.
module rmq_checker #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   input logic [2:0]                           rsp_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   localparam int W = FRAC_BITS + 2;

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // w is a square root, never negative
   a_w_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[W-1])
      else $error("negative w");

   // the dominant component is a root, never negative
   a_dom_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != rmq_pkg::PATH_TRACE |->
         !rsp_tdata[W*rsp_tuser[1:0] + W - 1])
      else $error("negative dominant component");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ----- test/testbench.sv -----
// Testbench for the rotation matrix to quaternion unit: scoreboard and random traffic.
`timescale 1ns / 100ps

class quat_scoreboard;
   typedef struct packed {
      logic [17:0] w;
      logic [17:0] x;
      logic [17:0] y;
      logic [17:0] z;
      rmq_pkg::path_type path;
      logic sat;
   } quat_type;

   logic [16:0] limit;
   quat_type pending_quats[$];
   int errors;

   function new();
      limit = rmq_pkg::LIMIT_RESET;
      errors = 0;
   endfunction

   // bitwise integer square root, rounded down
   function longint unsigned int_sqrt(longint unsigned a);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > a) b >>= 2;
      while (b != 0) begin
         if (a >= res + b) begin
            a -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // num * 2^16 / den toward zero, clipped to the field
   function logic [17:0] fx_quotient(longint num, longint unsigned den, ref logic sat);
      logic neg;
      longint unsigned mag;
      longint unsigned q;
      neg = num < 0;
      mag = neg ? -num : num;
      if (mag == 0) return 0;
      q = (den == 0) ? ~64'd0 : (mag << 16) / den;
      if (neg) begin
         if (q > (64'd1 << 17)) begin
            q = 64'd1 << 17;
            sat = 1;
         end
         return 18'(-q);
      end
      if (q > (64'd1 << 17) - 1) begin
         q = (64'd1 << 17) - 1;
         sat = 1;
      end
      return 18'(q);
   endfunction

   // work out the quaternion for one accepted matrix word
   function void note_matrix(logic [167:0] data);
      longint r[9];
      longint t;
      longint d;
      longint unsigned a;
      longint unsigned us;
      longint unsigned den;
      logic [17:0] root;
      logic s;
      quat_type q;
      for (int i = 0; i < 9; i++) r[i] = longint'($signed(data[i*18 +: 18]));
      q = '0;
      s = 1'b0;
      t = 65536 + r[0] + r[4] + r[8];
      a = t < 0 ? -t : t;
      q.w = 18'(int_sqrt(a << 16) >> 1);
      if (longint'(q.w) > longint'(limit)) begin
         den = longint'(q.w) << 2;
         q.path = rmq_pkg::PATH_TRACE;
         q.x = fx_quotient(r[7] - r[5], den, s);
         q.y = fx_quotient(r[2] - r[6], den, s);
         q.z = fx_quotient(r[3] - r[1], den, s);
      end else begin
         if (r[0] >= r[4] && r[0] >= r[8]) begin
            q.path = rmq_pkg::PATH_X;
            d = r[0];
         end else if (r[4] >= r[0] && r[4] >= r[8]) begin
            q.path = rmq_pkg::PATH_Y;
            d = r[4];
         end else begin
            q.path = rmq_pkg::PATH_Z;
            d = r[8];
         end
         us = (65536 + d < 0) ? 0 : 65536 + d;
         root = 18'(int_sqrt(us << 15));
         den = int_sqrt(us << 17);
         case (q.path)
            rmq_pkg::PATH_X: begin
               q.x = root;
               q.y = fx_quotient(r[1], den, s);
               q.z = fx_quotient(r[2], den, s);
            end
            rmq_pkg::PATH_Y: begin
               q.y = root;
               q.x = fx_quotient(r[3], den, s);
               q.z = fx_quotient(r[5], den, s);
            end
            default: begin
               q.z = root;
               q.x = fx_quotient(r[6], den, s);
               q.y = fx_quotient(r[7], den, s);
            end
         endcase
      end
      q.sat = s;
      pending_quats.push_back(q);
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_quat(logic [71:0] data, logic [2:0] user);
      quat_type e;
      if (pending_quats.size() == 0) begin
         report("unexpected word", 0, 0);
         return;
      end
      e = pending_quats.pop_front();
      if (data[17:0] !== e.w) report("quat_w", data[17:0], e.w);
      if (data[35:18] !== e.x) report("quat_x", data[35:18], e.x);
      if (data[53:36] !== e.y) report("quat_y", data[53:36], e.y);
      if (data[71:54] !== e.z) report("quat_z", data[71:54], e.z);
      if (user[1:0] !== e.path) report("path_taken", user[1:0], e.path);
      if (user[2] !== e.sat) report("saturated", user[2], e.sat);
   endtask
endclass

module testbench;

   localparam int LATENCY = 40;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_COUNT = 1700;

   logic clock = 0;
   logic reset = 1;
   logic [167:0] req_tdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [71:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [16:0] csr_data = '0;
   logic csr_valid = 0;
   logic csr_ready;
   logic stall_mode = 0;

   quat_scoreboard board = new();
   int idle_cycles = 0;

   rotation_matrix_to_quaternion_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_data(csr_data), .csr_valid(csr_valid), .csr_ready(csr_ready)
   );

   always #5 clock = ~clock;

   // result side: check words, stall on its own pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_quat(rsp_tdata, rsp_tuser);
   end
   always @(negedge clock) begin
      if (stall_mode) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1;
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one matrix word; valid stays up for a following word, idle drops it
   task send_matrix(logic [17:0] m[9]);
      logic [167:0] packed_word;
      packed_word = '0;
      for (int i = 0; i < 9; i++) packed_word[i*18 +: 18] = m[i];
      req_tdata <= packed_word;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      board.note_matrix(packed_word);
      @(negedge clock);
   endtask

   task drain();
      req_tvalid <= 0;
      while (board.pending_quats.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task write_limit(logic [16:0] value);
      drain();
      csr_data <= value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      board.limit = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // random element: extremes, near one, or anything
   function logic [17:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 18'h1ffff;
         1: return 18'h20000;
         2: return 18'($signed($urandom_range(0, 131072)) - 65536);
         3: return 18'(65536 - $urandom_range(0, 300));
         default: return 18'($urandom);
      endcase
   endfunction

   // rotation-like matrix: random entries, mostly with one diagonal near +1 and the others near -1
   function automatic void rand_rotation(ref logic [17:0] m[9]);
      int axis;
      axis = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) m[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
      if (axis < 3) begin
         for (int i = 0; i < 3; i++) m[i*4] = 18'(-65536 + $urandom_range(0, 2000));
         m[axis*4] = 18'(65536 - $urandom_range(0, 2000));
      end
   endfunction

   initial begin
      logic [17:0] m[9];
      int burst;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: identity, 180 degree turns, extremes, ties, zero numerators
      m = '{default: 18'h0};
      m[0] = 18'h10000; m[4] = 18'h10000; m[8] = 18'h10000;
      send_matrix(m);
      for (int ax = 0; ax < 3; ax++) begin
         m = '{default: 18'h0};
         for (int i = 0; i < 3; i++) m[i*4] = 18'(-65536);
         m[ax*4] = 18'h10000;
         send_matrix(m);
      end
      m = '{default: 18'h1ffff}; send_matrix(m);
      m = '{default: 18'h20000}; send_matrix(m);
      m = '{default: 18'h0}; send_matrix(m);
      // all diagonals minus one: trace -2, trace path with zero numerators
      m = '{default: 18'h20000};
      for (int i = 0; i < 3; i++) m[i*4] = 18'(-65536);
      send_matrix(m);
      m = '{default: 18'h1ffff};
      for (int i = 0; i < 3; i++) m[i*4] = 18'(-65536);
      send_matrix(m);
      // z takes the rest; y dominant tie with z
      m = '{default: 18'h0}; m[0] = 18'(-65536); m[4] = 18'h100; m[8] = 18'h100;
      m[8] = 18'h200; send_matrix(m);
      m[8] = 18'h100; send_matrix(m);
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 9; i++) m[i] = rand_elem();
         send_matrix(m);
      end

      // random phases across several thresholds
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_limit(17'd0);
            1: write_limit(17'h1ffff);
            2: write_limit(17'd66);
            3: write_limit(17'($urandom_range(0, 70000)));
            default: write_limit(17'($urandom_range(0, 2000)));
         endcase
         stall_mode <= phase[0];
         for (int n = 0; n < RANDOM_COUNT / 5; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++, n++) begin
               if (n == 100) drain();
               if ($urandom_range(0, 3) == 0) for (int i = 0; i < 9; i++) m[i] = rand_elem();
               else rand_rotation(m);
               send_matrix(m);
            end
            if ($urandom_range(0, 2) == 0) begin
               req_tvalid <= 0;
               repeat ($urandom_range(1, 12)) @(negedge clock);
            end
         end
      end

      drain();
      if (board.errors == 0 && board.pending_quats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
